[rtl/one_euro_filter_three_axis_top_defines.svh]
// Assertion macros of the one-euro filter top level.
// Depends on signals named clk and rst in the scope of each use.
`ifndef ONE_EURO_FILTER_THREE_AXIS_TOP_DEFINES_SVH
`define ONE_EURO_FILTER_THREE_AXIS_TOP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication check.
`define OEF_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication check.
`define OEF_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define OEF_CHECK_NOW(lbl, ante, cons)
`define OEF_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/oef_pkg.sv]
// Types and constants of the three-axis one-euro filter.
// No dependencies; used by all files of the block but oef_filt_if and the defines header.
`timescale 1ns / 1ps
`default_nettype none
package oef_pkg;
  localparam int AXIS_COUNT = 3;
  localparam int STEP_W     = 20;
  localparam int CFG_W      = 32;
  localparam int RATE_W     = 48;
  localparam int LP_W       = 50;
  localparam int DIV_W      = 64;
  localparam int DVS_W      = 34;
  localparam int FC_W       = 24;

  localparam logic [STEP_W-1:0] MIN_STEP   = 20'd1000;
  localparam logic [19:0]       MEGA       = 20'd1000000;
  localparam logic [18:0]       TWO_PI_Q16 = 19'd411775;
  localparam logic [63:0]       TAU_NUM    = 64'd67108864000000;
  localparam logic [FC_W-1:0]   CUT_CAP    = 24'hFFFFFF;

  typedef enum logic [1:0] {
    REG_ENABLE       = 2'd0,
    REG_MIN_CUTOFF   = 2'd1,
    REG_SPEED_GAIN   = 2'd2,
    REG_DERIV_CUTOFF = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_BUSY,
    T_HOLD
  } top_state_t;

  typedef enum logic [4:0] {
    L_IDLE, L_A_MUL1, L_A_MUL2, L_A_SUM, L_A_NORM, L_A_WAIT,
    L_R_GO1, L_R_WAIT1, L_R_MUL, L_R_GO2, L_R_WAIT2, L_R_FIN,
    L_LP_HI, L_LP_LO, L_LP_FIN, L_C_MUL1, L_C_MUL2, L_C_FIN
  } lane_state_t;

  typedef struct packed {
    logic go;
    logic restart;
    logic seed;
    logic filter;
  } lane_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

  // Clamp a wide signed value into the rate range.
  function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [LP_W-1:0] v);
    logic signed [LP_W-1:0] hi;
    logic signed [LP_W-1:0] lo;
    hi = LP_W'({1'b0, {(RATE_W-1){1'b1}}});
    lo = -hi - LP_W'(1);
    if (v > hi) return hi[RATE_W-1:0];
    if (v < lo) return lo[RATE_W-1:0];
    return v[RATE_W-1:0];
  endfunction
endpackage
`default_nettype wire

[rtl/oef_meas_if.sv]
// Input channel of the one-euro filter: one three-axis sample word.
// Depends on oef_pkg for the step width.
`timescale 1ns / 1ps
`default_nettype none
interface oef_meas_if import oef_pkg::*; #(parameter int SAMPLE_BITS = 32);
  logic valid;
  logic ready;
  logic signed [SAMPLE_BITS-1:0] meas_x;
  logic signed [SAMPLE_BITS-1:0] meas_y;
  logic signed [SAMPLE_BITS-1:0] meas_z;
  logic [STEP_W-1:0] step_us;
  logic restart;
  modport source(output valid, meas_x, meas_y, meas_z, step_us, restart, input ready);
  modport sink(input valid, meas_x, meas_y, meas_z, step_us, restart, output ready);
endinterface
`default_nettype wire

[rtl/oef_filt_if.sv]
// Output channel of the one-euro filter: one filtered sample word.
// No dependencies beyond the sample width parameter.
`timescale 1ns / 1ps
`default_nettype none
interface oef_filt_if #(parameter int SAMPLE_BITS = 32);
  logic valid;
  logic ready;
  logic signed [SAMPLE_BITS-1:0] out_x;
  logic signed [SAMPLE_BITS-1:0] out_y;
  logic signed [SAMPLE_BITS-1:0] out_z;
  logic passed_raw;
  modport source(output valid, out_x, out_y, out_z, passed_raw, input ready);
  modport sink(input valid, out_x, out_y, out_z, passed_raw, output ready);
endinterface
`default_nettype wire

[rtl/oef_cfg_if.sv]
// Configuration write channel of the one-euro filter.
// Depends on oef_pkg for the index type and data width.
`timescale 1ns / 1ps
`default_nettype none
interface oef_cfg_if import oef_pkg::*;;
  logic valid;
  logic ready;
  cfg_index_t index;
  logic [CFG_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/oef_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on oef_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none
module oef_div import oef_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);
  localparam int CNT_W = $clog2(DIV_W);

  logic [DVS_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   shifted;
  logic             fits;

  // Trial subtraction of one step.
  assign shifted = {rem, quo[DIV_W-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? DVS_W'(shifted - {1'b0, dvs}) : shifted[DVS_W-1:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
endmodule
`default_nettype wire

[rtl/oef_lane.sv]
// One axis of the one-euro filter: rate, both low-passes and cutoff.
// Depends on oef_pkg and instantiates oef_div.
`timescale 1ns / 1ps
`default_nettype none
module oef_lane import oef_pkg::*; #(
  parameter int SAMPLE_BITS = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lane_cmd_t                     cmd,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic [STEP_W-1:0]             dt,
  input  logic [16:0]                   min_cutoff,
  input  logic [24:0]                   speed_gain,
  input  logic [16:0]                   deriv_cutoff,
  output lane_stat_t                    stat,
  output logic signed [SAMPLE_BITS-1:0] y
);
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int SHIFT  = FRAC_BITS + 14;

  lane_state_t state, state_next;

  logic signed [SAMPLE_BITS-1:0] prior_raw;
  logic signed [SAMPLE_BITS-1:0] prior_smoothed;
  logic signed [RATE_W-1:0]      prior_rate;
  logic done;
  logic phase;

  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic [STEP_W-1:0]             dt_reg;
  logic signed [DIFF_W-1:0]      rdiff;
  logic [FC_W-1:0]               vcut;
  logic [42:0]                   a_prod;
  logic [63:0]                   a_num;
  logic [63:0]                   a_sum;
  logic [30:0]                   alpha;
  logic [39:0]                   q1;
  logic [19:0]                   r1;
  logic [59:0]                   qm;
  logic [40:0]                   rm;
  logic signed [RATE_W-1:0]      rate_f;
  logic signed [LP_W-1:0]        lp_x;
  logic signed [LP_W-1:0]        lp_p;
  logic [49:0]                   lp_hi;
  logic [29:0]                   lp_lo_m;
  logic [30:0]                   lp_lo;
  logic                          lp_neg;
  logic [48:0]                   c_lo;
  logic [48:0]                   c_hi;

  logic             div_start;
  logic [DIV_W-1:0] div_a;
  logic [DVS_W-1:0] div_b;
  logic             div_done;
  logic [DIV_W-1:0] div_q;
  logic [DVS_W-1:0] div_r;

  logic                   norm_ok;
  logic [FC_W-1:0]        fc_sel;
  logic [DIFF_W-1:0]      rmag;
  logic [60:0]            rv;
  logic [RATE_W-1:0]      rclip;
  logic signed [LP_W-1:0] rsigned;
  logic signed [LP_W-1:0] lp_d;
  logic [LP_W-2:0]        lp_m;
  logic [60:0]            lo_prod;
  logic [49:0]            lp_r;
  logic signed [LP_W-1:0] lp_y;
  logic [RATE_W-1:0]      sp;
  logic [72:0]            c_prod;
  logic [72:0]            c_add;
  logic [73:0]            c_sum;

  oef_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Shared arithmetic terms.
  assign norm_ok = (a_sum[63:33] == '0);
  assign fc_sel  = phase ? vcut : FC_W'(deriv_cutoff);
  assign rmag    = rdiff[DIFF_W-1] ? DIFF_W'(-rdiff) : DIFF_W'(rdiff);
  assign rv      = 61'(qm) + 61'(div_q[20:0]);
  assign rclip   = (rv > 61'(64'd1 << (RATE_W - 1))) ? RATE_W'(64'd1 << (RATE_W - 1))
                                                     : rv[RATE_W-1:0];
  assign rsigned = rdiff[DIFF_W-1] ? -LP_W'({1'b0, rclip}) : LP_W'({1'b0, rclip});
  assign lp_d    = lp_x - lp_p;
  assign lp_m    = lp_d[LP_W-1] ? (LP_W-1)'(-lp_d) : lp_d[LP_W-2:0];
  assign lo_prod = 61'(lp_lo_m) * 61'(alpha) + 61'(64'd1 << 29);
  assign lp_r    = lp_hi + 50'(lp_lo);
  assign lp_y    = lp_neg ? lp_p - LP_W'(lp_r) : lp_p + LP_W'(lp_r);
  assign sp      = rate_f[RATE_W-1] ? RATE_W'(-rate_f) : RATE_W'(rate_f);
  assign c_prod  = {c_hi, 24'b0} + 73'(c_lo);
  assign c_add   = c_prod >> SHIFT;
  assign c_sum   = 74'(min_cutoff) + 74'(c_add);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      L_IDLE:    if (cmd.go && cmd.filter) state_next = L_A_MUL1;
      L_A_MUL1:  state_next = L_A_MUL2;
      L_A_MUL2:  state_next = L_A_SUM;
      L_A_SUM:   state_next = L_A_NORM;
      L_A_NORM:  if (norm_ok) state_next = L_A_WAIT;
      L_A_WAIT:  if (div_done) state_next = phase ? L_LP_HI : L_R_GO1;
      L_R_GO1:   state_next = L_R_WAIT1;
      L_R_WAIT1: if (div_done) state_next = L_R_MUL;
      L_R_MUL:   state_next = L_R_GO2;
      L_R_GO2:   state_next = L_R_WAIT2;
      L_R_WAIT2: if (div_done) state_next = L_R_FIN;
      L_R_FIN:   state_next = L_LP_HI;
      L_LP_HI:   state_next = L_LP_LO;
      L_LP_LO:   state_next = L_LP_FIN;
      L_LP_FIN:  state_next = phase ? L_IDLE : L_C_MUL1;
      L_C_MUL1:  state_next = L_C_MUL2;
      L_C_MUL2:  state_next = L_C_FIN;
      L_C_FIN:   state_next = L_A_MUL1;
      default:   state_next = L_IDLE;
    endcase
  end

  // Divider requests.
  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = DVS_W'(dt_reg);
    unique case (state)
      L_A_NORM: begin
        div_start = norm_ok;
        div_a     = (a_num << 30) + (a_sum >> 1);
        div_b     = a_sum[DVS_W-1:0];
      end
      L_R_GO1: begin
        div_start = 1'b1;
        div_a     = DIV_W'(rmag);
      end
      L_R_GO2: begin
        div_start = 1'b1;
        div_a     = DIV_W'(rm);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= L_IDLE;
      done           <= 1'b0;
      phase          <= 1'b0;
      prior_raw      <= '0;
      prior_smoothed <= '0;
      prior_rate     <= '0;
    end else begin
      state <= state_next;
      case (state)
        L_IDLE: begin
          if (cmd.go) begin
            phase  <= 1'b0;
            x_reg  <= x;
            dt_reg <= dt;
            rdiff  <= DIFF_W'(x) - DIFF_W'(prior_raw);
            done   <= !cmd.filter;
            // A seeded sample overrides the cleared state of a restart.
            if (cmd.seed) begin
              prior_raw      <= x;
              prior_smoothed <= x;
              prior_rate     <= '0;
            end else if (cmd.restart) begin
              prior_raw      <= '0;
              prior_smoothed <= '0;
              prior_rate     <= '0;
            end
          end
        end
        L_A_MUL1: a_prod <= 43'(TWO_PI_Q16) * 43'(fc_sel);
        L_A_MUL2: a_num  <= 64'(a_prod) * 64'(dt_reg);
        L_A_SUM:  a_sum  <= a_num + TAU_NUM;
        L_A_NORM: begin
          if (!norm_ok) begin
            a_sum <= a_sum >> 1;
            a_num <= a_num >> 1;
          end
        end
        L_A_WAIT: begin
          if (div_done) begin
            alpha <= div_q[30:0];
            lp_x  <= LP_W'(x_reg);
            lp_p  <= LP_W'(prior_smoothed);
          end
        end
        L_R_WAIT1: begin
          if (div_done) begin
            q1 <= div_q[39:0];
            r1 <= div_r[19:0];
          end
        end
        L_R_MUL: begin
          qm <= 60'(q1) * 60'(MEGA);
          rm <= 41'(r1) * 41'(MEGA) + 41'(dt_reg >> 1);
        end
        L_R_FIN: begin
          lp_x <= LP_W'(sat_rate(rsigned));
          lp_p <= LP_W'(prior_rate);
        end
        L_LP_HI: begin
          lp_hi   <= 50'(lp_m[LP_W-2:30]) * 50'(alpha);
          lp_lo_m <= lp_m[29:0];
          lp_neg  <= lp_d[LP_W-1];
        end
        L_LP_LO: lp_lo <= lo_prod[60:30];
        L_LP_FIN: begin
          if (phase) begin
            y              <= lp_y[SAMPLE_BITS-1:0];
            prior_raw      <= x_reg;
            prior_smoothed <= lp_y[SAMPLE_BITS-1:0];
            prior_rate     <= rate_f;
            done           <= 1'b1;
          end else begin
            rate_f <= sat_rate(lp_y);
          end
        end
        L_C_MUL1: c_lo <= 49'(sp[23:0]) * 49'(speed_gain);
        L_C_MUL2: c_hi <= 49'(sp[47:24]) * 49'(speed_gain);
        L_C_FIN: begin
          phase <= 1'b1;
          vcut  <= (c_add >= 73'(CUT_CAP) || c_sum > 74'(CUT_CAP)) ? CUT_CAP
                                                                  : c_sum[FC_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign stat.busy = (state != L_IDLE);
  assign stat.done = done;
endmodule
`default_nettype wire

[rtl/one_euro_filter_three_axis_top.sv]
// Three-axis one-euro filter. An accepted sample's word, pass-through or filtered, is loaded
// into the output register once that register is free, and only then is the next sample taken.
// A filtered word also waits on each axis lane's serial divider, which runs four 64-step
// divisions (two for alpha, two for the rate), and on two normalizing shifts ahead of the
// alpha divisions.
// The axes run in parallel lanes and the result word is merged into an output register, so
// the next sample is taken while a result waits.
// Depends on oef_pkg, the three channel interfaces and oef_lane.
`timescale 1ns / 1ps
`default_nettype none
`include "one_euro_filter_three_axis_top_defines.svh"
module one_euro_filter_three_axis_top import oef_pkg::*; #(
  parameter int SAMPLE_BITS = 32,
  parameter int FRAC_BITS   = 16
) (
  input logic         clk,
  input logic         rst,
  oef_meas_if.sink    meas,
  oef_filt_if.source  filt,
  oef_cfg_if.sink     cfg
);
  top_state_t state, state_next;

  logic        enable;
  logic [16:0] min_cutoff;
  logic [24:0] speed_gain;
  logic [16:0] deriv_cutoff;
  logic        first_pending;
  logic        bypass_hold;

  logic signed [SAMPLE_BITS-1:0] samp     [AXIS_COUNT];
  logic signed [SAMPLE_BITS-1:0] raw_hold [AXIS_COUNT];
  logic signed [SAMPLE_BITS-1:0] lane_y   [AXIS_COUNT];
  lane_stat_t                    lane_stat [AXIS_COUNT];
  logic [AXIS_COUNT-1:0]         done_bits;
  logic [AXIS_COUNT-1:0]         busy_bits;

  lane_cmd_t         cmd;
  logic              accept;
  logic              fp_eff;
  logic              bypass;
  logic              out_free;
  logic [STEP_W-1:0] dt;

  assign samp[0] = meas.meas_x;
  assign samp[1] = meas.meas_y;
  assign samp[2] = meas.meas_z;

  assign accept   = meas.valid && meas.ready;
  assign fp_eff   = meas.restart || first_pending;
  assign bypass   = !enable || fp_eff;
  assign out_free = !filt.valid || filt.ready;
  assign dt       = (meas.step_us < MIN_STEP) ? MIN_STEP : meas.step_us;
  assign cfg.ready = 1'b1;

  // Axis lanes.
  for (genvar i = 0; i < AXIS_COUNT; i++) begin : g_lane
    oef_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
    ) u_lane (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .x            (samp[i]),
      .dt           (dt),
      .min_cutoff   (min_cutoff),
      .speed_gain   (speed_gain),
      .deriv_cutoff (deriv_cutoff),
      .stat         (lane_stat[i]),
      .y            (lane_y[i])
    );
    assign done_bits[i] = lane_stat[i].done;
    assign busy_bits[i] = lane_stat[i].busy;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:  if (accept) state_next = bypass ? T_HOLD : T_BUSY;
      T_BUSY:  if (&done_bits) state_next = T_HOLD;
      T_HOLD:  if (out_free) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  // Handshake and lane commands.
  always_comb begin
    meas.ready  = (state == T_IDLE);
    cmd.go      = accept;
    cmd.restart = meas.restart;
    cmd.seed    = enable && fp_eff;
    cmd.filter  = !bypass;
  end

  // Configuration registers and sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      enable        <= 1'b0;
      min_cutoff    <= 17'd512;
      speed_gain    <= 25'd117440;
      deriv_cutoff  <= 17'd1024;
      first_pending <= 1'b1;
      filt.valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_ENABLE:       enable       <= cfg.data[0];
          REG_MIN_CUTOFF:   min_cutoff   <= cfg.data[16:0];
          REG_SPEED_GAIN:   speed_gain   <= cfg.data[24:0];
          REG_DERIV_CUTOFF: deriv_cutoff <= cfg.data[16:0];
          default: ;
        endcase
      end
      if (accept) begin
        bypass_hold <= bypass;
        for (int i = 0; i < AXIS_COUNT; i++) raw_hold[i] <= samp[i];
        // Seeding consumes the first sample, even one that follows a restart.
        if (enable && fp_eff) first_pending <= 1'b0;
        else if (meas.restart) first_pending <= 1'b1;
      end
      if (state == T_HOLD && out_free) begin
        filt.valid      <= 1'b1;
        filt.passed_raw <= bypass_hold;
        filt.out_x      <= bypass_hold ? raw_hold[0] : lane_y[0];
        filt.out_y      <= bypass_hold ? raw_hold[1] : lane_y[1];
        filt.out_z      <= bypass_hold ? raw_hold[2] : lane_y[2];
      end else if (filt.ready) begin
        filt.valid <= 1'b0;
      end
    end
  end

  `OEF_CHECK_NEXT(a_accept_leaves_idle, accept, state != T_IDLE)
  `OEF_CHECK_NOW(a_idle_lanes_quiet, state == T_IDLE, busy_bits == '0)
  `OEF_CHECK_NEXT(a_hold_loads_output, state == T_HOLD && out_free, filt.valid)
endmodule
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the three-axis one-euro filter top level.
// Depends on oef_pkg, the meas/filt/cfg channel interfaces and the filter RTL.
`timescale 1ns / 1ps
module tb;
  import oef_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  typedef struct {
    logic signed [31:0] ax[3];
    logic [19:0]        step;
    logic               restart;
  } sample_t;

  typedef struct {
    logic signed [31:0] ax[3];
    logic               raw;
  } smooth_t;

  typedef struct {
    bit         is_cfg;
    cfg_index_t idx;
    logic [31:0] data;
    sample_t    s;
    bit         typed;
  } stim_row_t;

  logic clk;
  logic rst;

  oef_meas_if #(.SAMPLE_BITS(32)) meas_ch ();
  oef_filt_if #(.SAMPLE_BITS(32)) filt_ch ();
  oef_cfg_if cfg_ch ();

  one_euro_filter_three_axis_top uut (
    .clk (clk),
    .rst (rst),
    .meas(meas_ch),
    .filt(filt_ch),
    .cfg (cfg_ch)
  );

  // Shadow copy of the filter registers and per-axis state.
  bit                 en_shadow;
  longint unsigned    min_cut_shadow;
  longint unsigned    gain_shadow;
  longint unsigned    deriv_cut_shadow;
  longint             last_raw[3];
  longint             last_smooth[3];
  longint             last_rate[3];
  bit                 awaiting_first;

  smooth_t   pending_words[$];
  stim_row_t stim_rows[$];
  int        fail_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        quiet_cycles;
  longint    walk[3];

  // Clock: 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Clamp a value into the signed 48-bit rate range.
  function automatic longint clamp_rate(input longint v);
    longint hi;
    hi = (64'sd1 <<< 47) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Smoothing factor in Q30 for a cutoff in 1/1024 Hz and a step in us.
  function automatic longint unsigned smoothing_q30(input longint unsigned fc,
                                                     input longint unsigned dt);
    longint unsigned num;
    longint unsigned sum;
    num = 64'd411775 * fc * dt;
    sum = num + TAU_NUM;
    while ((sum >> 33) != 0) begin
      sum = sum >> 1;
      num = num >> 1;
    end
    return ((num << 30) + (sum >> 1)) / sum;
  endfunction

  // Rounded (half away from zero) product of d and a Q30 factor.
  function automatic longint scale_q30(input longint d, input longint unsigned a);
    longint unsigned m;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned r;
    m  = (d < 0) ? longint'(-d) : d;
    hi = m >> 30;
    lo = m & ((64'd1 << 30) - 1);
    r  = hi * a + ((lo * a + (64'd1 << 29)) >> 30);
    return (d < 0) ? -longint'(r) : longint'(r);
  endfunction

  // Per-second rate of change of one axis, rounded and saturated.
  function automatic longint axis_rate(input longint diff, input longint unsigned dt);
    longint unsigned m;
    longint unsigned v;
    m = (diff < 0) ? longint'(-diff) : diff;
    v = (m / dt) * 64'd1000000 + ((m % dt) * 64'd1000000 + dt / 2) / dt;
    if (v > (64'd1 << 47)) v = 64'd1 << 47;
    return clamp_rate((diff < 0) ? -longint'(v) : longint'(v));
  endfunction

  // Speed-dependent cutoff, saturating at the 24-bit cap.
  function automatic longint unsigned speed_cutoff(input longint rate);
    longint unsigned sp;
    longint unsigned add;
    sp = (rate < 0) ? longint'(-rate) : rate;
    if (gain_shadow != 0 && sp > (64'hFFFF_FFFF_FFFF_FFFF / gain_shadow))
      return 64'hFFFFFF;
    add = (sp * gain_shadow) >> 30;
    if (add >= 64'hFFFFFF || min_cut_shadow + add > 64'hFFFFFF) return 64'hFFFFFF;
    return min_cut_shadow + add;
  endfunction

  function automatic void clear_axes();
    for (int i = 0; i < 3; i++) begin
      last_raw[i] = 0;
      last_smooth[i] = 0;
      last_rate[i] = 0;
    end
    awaiting_first = 1'b1;
  endfunction

  // Filter one accepted sample and advance the shadow state.
  function automatic smooth_t filter_sample(input sample_t s);
    smooth_t         res;
    longint          xv[3];
    longint unsigned dt;
    longint unsigned a_rate;
    longint          fr;
    longint          y;
    dt = (s.step < MIN_STEP) ? 64'd1000 : 64'(s.step);
    for (int i = 0; i < 3; i++) xv[i] = s.ax[i];
    if (s.restart) clear_axes();
    if (!en_shadow || awaiting_first) begin
      if (en_shadow) begin
        for (int i = 0; i < 3; i++) begin
          last_raw[i] = xv[i];
          last_smooth[i] = xv[i];
          last_rate[i] = 0;
        end
        awaiting_first = 1'b0;
      end
      for (int i = 0; i < 3; i++) res.ax[i] = s.ax[i];
      res.raw = 1'b1;
      return res;
    end
    a_rate = smoothing_q30(deriv_cut_shadow, dt);
    for (int i = 0; i < 3; i++) begin
      fr = clamp_rate(last_rate[i] +
                      scale_q30(axis_rate(xv[i] - last_raw[i], dt) - last_rate[i], a_rate));
      y = last_smooth[i] +
          scale_q30(xv[i] - last_smooth[i], smoothing_q30(speed_cutoff(fr), dt));
      last_raw[i] = xv[i];
      last_smooth[i] = y;
      last_rate[i] = fr;
      res.ax[i] = y[31:0];
    end
    res.raw = 1'b0;
    return res;
  endfunction

  function automatic void shadow_write(input cfg_index_t idx, input logic [31:0] data);
    case (idx)
      REG_ENABLE:       en_shadow = data[0];
      REG_MIN_CUTOFF:   min_cut_shadow = 64'(data[16:0]);
      REG_SPEED_GAIN:   gain_shadow = 64'(data[24:0]);
      REG_DERIV_CUTOFF: deriv_cut_shadow = 64'(data[16:0]);
      default: ;
    endcase
  endfunction

  function automatic void add_item(input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] z, input logic [19:0] step,
                                   input logic rs, input bit typed);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.idx = REG_ENABLE;
    r.data = '0;
    r.s.ax[0] = x;
    r.s.ax[1] = y;
    r.s.ax[2] = z;
    r.s.step = step;
    r.s.restart = rs;
    r.typed = typed;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input cfg_index_t idx, input logic [31:0] data);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    r.typed = 1'b0;
    for (int i = 0; i < 3; i++) r.s.ax[i] = '0;
    r.s.step = '0;
    r.s.restart = 1'b0;
    stim_rows.push_back(r);
  endfunction

  // Send one sample word, idling at random; queue its expected result on acceptance.
  task automatic send_sample(input sample_t s, input bit typed);
    smooth_t p;
    forever begin
      @(negedge clk);
      if ($urandom_range(99) < send_idle_pct) begin
        meas_ch.valid <= 1'b0;
      end else begin
        meas_ch.valid   <= 1'b1;
        meas_ch.meas_x  <= s.ax[0];
        meas_ch.meas_y  <= s.ax[1];
        meas_ch.meas_z  <= s.ax[2];
        meas_ch.step_us <= s.step;
        meas_ch.restart <= s.restart;
        break;
      end
    end
    do @(posedge clk); while (!meas_ch.ready);
    p = filter_sample(s);
    if (typed) begin
      // Pass-through words must echo the raw sample.
      for (int i = 0; i < 3; i++) p.ax[i] = s.ax[i];
      p.raw = 1'b1;
    end
    pending_words.push_back(p);
  endtask

  // Wait until every expected word has come back.
  task automatic drain();
    @(negedge clk);
    meas_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Register write; the caller drains first and lowers valid afterwards.
  task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    shadow_write(idx, data);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_cutoff();
    case ($urandom_range(4))
      0: return 32'd1;
      1: return 32'd102400;
      2: return 32'd0;
      3: return 32'd512;
      default: return $urandom_range(102400, 1);
    endcase
  endfunction

  task automatic random_setup();
    logic [31:0] g;
    drain();
    case ($urandom_range(3))
      0: g = 32'd0;
      1: g = 32'd16777216;
      2: g = 32'd117440;
      default: g = $urandom_range(16777216);
    endcase
    write_reg(REG_ENABLE, ($urandom_range(9) != 0) ? 32'd1 : 32'd0);
    write_reg(REG_MIN_CUTOFF, pick_cutoff());
    write_reg(REG_SPEED_GAIN, g);
    write_reg(REG_DERIV_CUTOFF, pick_cutoff());
    end_writes();
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    int      r;
    longint  amp;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(99) < 5) begin
        walk[i] = $signed($urandom());
      end else begin
        amp = 64'd1 << $urandom_range(24);
        walk[i] = walk[i] + $signed($urandom_range(2 * amp)) - amp;
        if (walk[i] > 64'sh7FFFFFFF) walk[i] = 64'sh7FFFFFFF;
        if (walk[i] < -64'sh80000000) walk[i] = -64'sh80000000;
      end
      s.ax[i] = walk[i][31:0];
    end
    r = $urandom_range(99);
    if (r < 10) s.step = 20'($urandom_range(999));
    else if (r < 80) s.step = 20'($urandom_range(20000, 1000));
    else if (r < 85) s.step = 20'd1000000;
    else s.step = 20'($urandom_range(1000000));
    s.restart = ($urandom_range(99) < 3);
    return s;
  endfunction

  // Receiver: random stalls, changed at the falling edge.
  always @(negedge clk) begin
    filt_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker: compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    smooth_t e;
    if (!rst && filt_ch.valid && filt_ch.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h z=%h raw=%b", $time,
                 filt_ch.out_x, filt_ch.out_y, filt_ch.out_z, filt_ch.passed_raw);
        fail_count++;
      end else begin
        e = pending_words.pop_front();
        if (filt_ch.out_x !== e.ax[0]) begin
          $display("%0t: out_x expected %h got %h", $time, e.ax[0], filt_ch.out_x);
          fail_count++;
        end
        if (filt_ch.out_y !== e.ax[1]) begin
          $display("%0t: out_y expected %h got %h", $time, e.ax[1], filt_ch.out_y);
          fail_count++;
        end
        if (filt_ch.out_z !== e.ax[2]) begin
          $display("%0t: out_z expected %h got %h", $time, e.ax[2], filt_ch.out_z);
          fail_count++;
        end
        if (filt_ch.passed_raw !== e.raw) begin
          $display("%0t: passed_raw expected %b got %b", $time, e.raw,
                   filt_ch.passed_raw);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if (rst || (meas_ch.valid && meas_ch.ready) || (filt_ch.valid && filt_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    meas_ch.valid = 1'b0;
    meas_ch.meas_x = '0;
    meas_ch.meas_y = '0;
    meas_ch.meas_z = '0;
    meas_ch.step_us = '0;
    meas_ch.restart = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ENABLE;
    cfg_ch.data = '0;
    filt_ch.ready = 1'b0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    for (int i = 0; i < 3; i++) walk[i] = 0;
    en_shadow = 1'b0;
    min_cut_shadow = 512;
    gain_shadow = 117440;
    deriv_cut_shadow = 1024;
    clear_axes();

    // Directed table: disabled pass-through, first sample, short and long steps,
    // restart, extreme jumps, large and zero cutoffs, register masking.
    add_item(32'h7FFFFFFF, 32'h80000000, 32'h00000000, 20'd0, 1'b0, 1'b1);
    add_item(32'hFFFFFFFF, 32'h00000001, 32'h12345678, 20'd1000000, 1'b1, 1'b1);
    add_cfg(REG_ENABLE, 32'd1);
    add_item(32'h00010000, 32'hFFFF0000, 32'h00000000, 20'd1000, 1'b0, 1'b1);
    add_item(32'h00020000, 32'hFFFE0000, 32'h00000100, 20'd0, 1'b0, 1'b0);
    add_item(32'h7FFFFFFF, 32'h80000000, 32'h00001000, 20'd999, 1'b0, 1'b0);
    add_item(32'h80000000, 32'h7FFFFFFF, 32'hFFFFF000, 20'd1000, 1'b0, 1'b0);
    add_item(32'h00000000, 32'h00000000, 32'h00000000, 20'd1000000, 1'b0, 1'b0);
    add_item(32'h00030000, 32'h00040000, 32'h00050000, 20'd5000, 1'b1, 1'b1);
    add_item(32'h00031000, 32'h0003F000, 32'h00052000, 20'd5000, 1'b0, 1'b0);
    add_cfg(REG_SPEED_GAIN, 32'd16777216);
    add_cfg(REG_MIN_CUTOFF, 32'd102400);
    add_cfg(REG_DERIV_CUTOFF, 32'd102400);
    add_item(32'h7FFFFFFF, 32'h80000000, 32'h40000000, 20'd1000, 1'b0, 1'b0);
    add_item(32'h80000000, 32'h7FFFFFFF, 32'hC0000000, 20'd1000, 1'b0, 1'b0);
    add_cfg(REG_SPEED_GAIN, 32'd0);
    add_cfg(REG_MIN_CUTOFF, 32'd0);
    add_cfg(REG_DERIV_CUTOFF, 32'h00020000);
    add_item(32'h00100000, 32'hFFF00000, 32'h00000001, 20'd2000, 1'b0, 1'b0);
    add_item(32'h00200000, 32'hFFE00000, 32'h00000002, 20'd2000, 1'b0, 1'b0);
    add_cfg(REG_MIN_CUTOFF, 32'd1);
    add_cfg(REG_DERIV_CUTOFF, 32'd1);
    add_item(32'h00300000, 32'hFFD00000, 32'h00000003, 20'd1000000, 1'b0, 1'b0);
    add_cfg(REG_MIN_CUTOFF, 32'hFFFE0200);
    add_cfg(REG_SPEED_GAIN, 32'hFE01CAC0);
    add_cfg(REG_DERIV_CUTOFF, 32'hFFFE0400);
    add_item(32'h00310000, 32'hFFD10000, 32'h00010003, 20'd10000, 1'b0, 1'b0);
    add_cfg(REG_ENABLE, 32'hFFFFFFFE);
    add_item(32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F, 20'd3000, 1'b0, 1'b1);

    // Hold reset, then release it at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    foreach (stim_rows[k]) begin
      if (stim_rows[k].is_cfg) begin
        drain();
        write_reg(stim_rows[k].idx, stim_rows[k].data);
        end_writes();
      end else begin
        send_sample(stim_rows[k].s, stim_rows[k].typed);
      end
    end

    // Random part in four idling phases, with a new setting every 50 words.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int n = 0; n < 250; n++) begin
        if (n % 50 == 0) random_setup();
        send_sample(random_sample(), 1'b0);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

[one_euro_filter_three_axis_top.f]
+incdir+rtl
rtl/oef_pkg.sv
rtl/oef_meas_if.sv
rtl/oef_filt_if.sv
rtl/oef_cfg_if.sv
rtl/oef_div.sv
rtl/oef_lane.sv
rtl/one_euro_filter_three_axis_top.sv
sim/tb.sv
